// ===== rtl/core/dcrd_pkg.sv =====
// ----------------------------------------------------------------------------
// dcrd_pkg
// Shared types and constants for the DCT coefficient run decoder.
// ----------------------------------------------------------------------------
package dcrd_pkg;

  localparam int COMPONENT_SLOTS_DEF = 4;
  localparam int SLOT_FIELD_W        = 2;
  localparam int VAL_W               = 12;
  localparam int COEFF_W             = 16;
  localparam int QUEUE_DEPTH         = 2;
  localparam int QPTR_W              = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W              = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_COEFF = 2'd0,
    KIND_ZRL   = 2'd1,
    KIND_EOB   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [5:0]               position;
    logic signed [VAL_W-1:0]  value;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic                     is_dc;
    logic                     restart;
    logic                     last;
  } entry_t;

endpackage

// ===== rtl/core/dcrd_front.sv =====
// ----------------------------------------------------------------------------
// dcrd_front
// Tracks the zigzag index and classifies each symbol into a queue entry.
// ----------------------------------------------------------------------------
module dcrd_front #(
  parameter int COMPONENT_SLOTS = dcrd_pkg::COMPONENT_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          symbol,
  input  logic [10:0]                         extra_bits,
  input  logic [dcrd_pkg::SLOT_FIELD_W-1:0]   component_slot,
  input  logic                                restart,
  input  logic                                q_full,
  output logic                                push,
  output dcrd_pkg::entry_t                    push_entry
);

  localparam logic [5:0] ZZ_TO_NAT [64] = '{
     6'd0,  6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  localparam logic [3:0] RUN_ZRL  = 4'hF;
  localparam logic [3:0] RUN_NONE = 4'h0;
  localparam logic [3:0] MAX_AC_SIZE = 4'd10;
  localparam logic [7:0] MAX_DC_CAT  = 8'd11;
  localparam logic [2:0] SLOTS_C = 3'(COMPONENT_SLOTS);

  function automatic logic signed [dcrd_pkg::VAL_W-1:0] extend_bits(
    input logic [10:0] raw,
    input logic [3:0]  size
  );
    logic [11:0] full;
    logic [11:0] half;
    logic [11:0] mag;
    full = (12'd1 << size) - 12'd1;
    half = 12'd1 << (size - 4'd1);
    mag  = {1'b0, raw} & full;
    if (size == 4'd0 || size > 4'd11) begin
      extend_bits = '0;
    end else if (mag < half) begin
      extend_bits = $signed(mag - full);
    end else begin
      extend_bits = $signed(mag);
    end
  endfunction

  function automatic logic [dcrd_pkg::SLOT_FIELD_W-1:0] slot_mod(
    input logic [dcrd_pkg::SLOT_FIELD_W-1:0] s
  );
    logic [2:0] r;
    r = {1'b0, s};
    for (int i = 0; i < 4; i++) begin
      if (r >= SLOTS_C) begin
        r = r - SLOTS_C;
      end
    end
    slot_mod = r[dcrd_pkg::SLOT_FIELD_W-1:0];
  endfunction

  logic [5:0]       idx_r;
  logic [5:0]       idx_nxt;
  logic [3:0]       run;
  logic [3:0]       size;
  logic [6:0]       reach;
  dcrd_pkg::entry_t ent;

  assign run      = symbol[7:4];
  assign size     = symbol[3:0];
  assign reach    = {1'b0, idx_r} + {3'b0, run};
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    ent          = '0;
    ent.kind     = dcrd_pkg::KIND_ERROR;
    ent.slot     = slot_mod(component_slot);
    ent.restart  = restart;
    ent.last     = 1'b1;
    idx_nxt      = '0;
    if (idx_r == 6'd0) begin
      if (symbol <= MAX_DC_CAT) begin
        ent.kind  = dcrd_pkg::KIND_COEFF;
        ent.is_dc = 1'b1;
        ent.value = extend_bits(extra_bits, size);
        ent.last  = 1'b0;
        idx_nxt   = 6'd1;
      end
    end else begin
      priority if (reach > 7'd63 || size > MAX_AC_SIZE) begin
        ent.kind = dcrd_pkg::KIND_ERROR;
      end else if (run == RUN_NONE && size == 4'd0) begin
        ent.kind = dcrd_pkg::KIND_EOB;
      end else if (run == RUN_ZRL && size == 4'd0) begin
        ent.kind     = dcrd_pkg::KIND_ZRL;
        ent.position = ZZ_TO_NAT[idx_r];
        ent.last     = (idx_r == 6'd48);
        idx_nxt      = idx_r + 6'd16;
      end else if (size == 4'd0) begin
        ent.kind = dcrd_pkg::KIND_ERROR;
      end else begin
        ent.kind     = dcrd_pkg::KIND_COEFF;
        ent.position = ZZ_TO_NAT[reach[5:0]];
        ent.value    = extend_bits(extra_bits, size);
        ent.last     = (reach == 7'd63);
        idx_nxt      = reach[5:0] + 6'd1;
      end
    end
  end

  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (push) begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== rtl/core/dcrd_queue.sv =====
// ----------------------------------------------------------------------------
// dcrd_queue
// Short FIFO of classified entries between the front and back parts.
// ----------------------------------------------------------------------------
module dcrd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dcrd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output dcrd_pkg::entry_t head
);

  localparam int DEPTH = dcrd_pkg::QUEUE_DEPTH;

  dcrd_pkg::entry_t                mem [DEPTH];
  logic [dcrd_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [dcrd_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [dcrd_pkg::QCNT_W-1:0]     cnt_r;

  assign full  = (cnt_r == dcrd_pkg::QCNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == dcrd_pkg::QPTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == dcrd_pkg::QPTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/dcrd_back.sv =====
// ----------------------------------------------------------------------------
// dcrd_back
// Applies restarts and DC prediction, and holds the result register.
// ----------------------------------------------------------------------------
module dcrd_back #(
  parameter int COMPONENT_SLOTS = dcrd_pkg::COMPONENT_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                empty,
  input  dcrd_pkg::entry_t                    head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dcrd_pkg::kind_t                     out_kind,
  output logic [5:0]                          out_position,
  output logic signed [dcrd_pkg::COEFF_W-1:0] out_coeff,
  output logic                                out_last
);

  localparam int SLOT_W = (COMPONENT_SLOTS > 1) ? $clog2(COMPONENT_SLOTS) : 1;
  localparam logic signed [16:0] SAT_MAX = 17'sd32767;
  localparam logic signed [16:0] SAT_MIN = -17'sd32768;

  logic signed [dcrd_pkg::COEFF_W-1:0] pred_r [COMPONENT_SLOTS];
  logic signed [dcrd_pkg::COEFF_W-1:0] pred_cur;
  logic signed [16:0]                  sum;
  logic signed [dcrd_pkg::COEFF_W-1:0] sat;
  logic [SLOT_W-1:0]                   slot;

  logic                                valid_r;
  dcrd_pkg::kind_t                     kind_r;
  logic [5:0]                          pos_r;
  logic signed [dcrd_pkg::COEFF_W-1:0] coeff_r;
  logic                                last_r;

  assign pop  = !empty && (!valid_r || out_ready);
  assign slot = head.slot[SLOT_W-1:0];
  assign pred_cur = head.restart ? '0 : pred_r[slot];
  assign sum = 17'(pred_cur) + 17'(head.value);

  always_comb begin
    priority if (sum > SAT_MAX) begin
      sat = 16'sh7FFF;
    end else if (sum < SAT_MIN) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COMPONENT_SLOTS; i++) begin
        pred_r[i] <= '0;
      end
    end else if (pop) begin
      for (int i = 0; i < COMPONENT_SLOTS; i++) begin
        if (head.is_dc && slot == SLOT_W'(i)) begin
          pred_r[i] <= sat;
        end else if (head.restart) begin
          pred_r[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= head.kind;
      pos_r   <= head.position;
      coeff_r <= head.is_dc ? sat : 16'(head.value);
      last_r  <= head.last;
    end
  end

  assign out_valid    = valid_r;
  assign out_kind     = kind_r;
  assign out_position = pos_r;
  assign out_coeff    = coeff_r;
  assign out_last     = last_r;

endmodule

// ===== rtl/core/dct_coefficient_run_decoder_core.sv =====
// Path: an accepted symbol is written into the queue, then popped into the result register.
// Throughput: 1 symbol per cycle while out_tready is high; the 2-entry queue and result register decouple stalls.
// Reset (rst_n low, synchronous): block index to 0, DC predictors to 0, queue and
// result register empty.
// ----------------------------------------------------------------------------
// dct_coefficient_run_decoder_core
// Decodes JPEG run/size symbols into positioned coefficients with DC prediction.
// ----------------------------------------------------------------------------
module dct_coefficient_run_decoder_core #(
  parameter int COMPONENT_SLOTS = dcrd_pkg::COMPONENT_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // symbol[7:0], extra_bits[18:8], component_slot[20:19]
  input  logic        in_tuser,   // restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // position[5:0], coeff_value[21:6]
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // block_last
);

  logic                                q_full;
  logic                                q_empty;
  logic                                push;
  logic                                pop;
  dcrd_pkg::entry_t                    push_entry;
  dcrd_pkg::entry_t                    head;
  dcrd_pkg::kind_t                     kind;
  logic [5:0]                          position;
  logic signed [dcrd_pkg::COEFF_W-1:0] coeff;

  dcrd_front #(.COMPONENT_SLOTS(COMPONENT_SLOTS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .symbol         (in_tdata[7:0]),
    .extra_bits     (in_tdata[18:8]),
    .component_slot (in_tdata[20:19]),
    .restart        (in_tuser),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  dcrd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  dcrd_back #(.COMPONENT_SLOTS(COMPONENT_SLOTS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (q_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (kind),
    .out_position (position),
    .out_coeff    (coeff),
    .out_last     (out_tlast)
  );

  assign out_tuser = kind;
  assign out_tdata = {2'b00, coeff, position};

endmodule
